// File: sv/efd_pkg.sv
// Package for the extended float divider: widths, exponent limits, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package efd_pkg;
  localparam int MantBits = 64;
  localparam int CntBits  = $clog2(MantBits + 1);
  localparam int ExpBits  = 16;
  // internal exponent width, wide enough for difference and decrements
  localparam int EwBits   = 19;
  localparam logic signed [EwBits-1:0] ExpMin = -19'sd16382;
  localparam logic signed [EwBits-1:0] ExpMax = 19'sd16383;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_NORM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic shift;
  } ctl_t;
endpackage

// File: sv/efd_core.sv
// Datapath of the extended float divider: remainder, quotient, exponent registers and
// one shared subtract/shift unit. Depends on efd_pkg.
`timescale 1ns / 1ps
module efd_core
  import efd_pkg::*;
(
  input  logic                        clk,
  input  ctl_t                        ctl,
  input  logic                        dividend_sign,
  input  logic signed [ExpBits-1:0]   dividend_exp,
  input  logic [MantBits-1:0]         dividend_mant,
  input  logic                        divisor_sign,
  input  logic signed [ExpBits-1:0]   divisor_exp,
  input  logic [MantBits-1:0]         divisor_mant,
  output logic                        skip,
  output logic                        q_top,
  output logic                        quot_sign,
  output logic signed [ExpBits-1:0]   quot_exp,
  output logic [MantBits-1:0]         quot_mant,
  output logic                        underflow_flag,
  output logic                        div_zero_flag
);
  logic [MantBits-1:0]       rem, dvs, quo;
  logic signed [EwBits-1:0]  ex;
  logic                      sgn, unf, dz;
  logic signed [EwBits-1:0]  ex_init;
  logic [MantBits-1:0]       b_half;
  logic                      zero_a, unf_c, dz_c;
  logic [MantBits:0]         diff;
  logic                      ge;

  // decode the operands at load
  always_comb begin
    zero_a  = (dividend_mant == '0);
    b_half  = divisor_mant >> 1;
    ex_init = EwBits'(dividend_exp) - EwBits'(divisor_exp) + EwBits'(2);
    unf_c   = !zero_a && (ex_init < ExpMin);
    dz_c    = !zero_a && (b_half == '0);
  end

  // shared subtractor
  always_comb begin
    diff = {1'b0, rem} - {1'b0, dvs};
    ge   = !diff[MantBits];
  end

  assign skip  = zero_a || unf_c || dz_c;
  assign q_top = quo[MantBits-1] || (quo == '0);

  // load, divide step, normalize shift
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= dividend_mant >> 1;
      dvs <= b_half;
      quo <= '0;
      unf <= unf_c;
      dz  <= dz_c;
      sgn <= zero_a ? dividend_sign : (dividend_sign ^ divisor_sign);
      if (zero_a)    ex <= '0;
      else if (dz_c) ex <= ExpMax;
      else if (unf_c) ex <= ExpMin;
      else           ex <= ex_init;
    end else if (ctl.step) begin
      quo <= {quo[MantBits-2:0], ge};
      rem <= ge ? {diff[MantBits-2:0], 1'b0} : {rem[MantBits-2:0], 1'b0};
    end else if (ctl.shift) begin
      quo <= {quo[MantBits-2:0], 1'b0};
      ex  <= ex - EwBits'(1);
    end
  end

  // saturate exponent on output
  always_comb begin
    quot_sign      = sgn;
    quot_mant      = quo;
    underflow_flag = unf;
    div_zero_flag  = dz;
    if (ex > EwBits'(32767))       quot_exp = 16'sh7fff;
    else if (ex < -EwBits'(32768)) quot_exp = 16'sh8000;
    else                           quot_exp = ExpBits'(ex);
  end
endmodule

// File: sv/efd_seq.sv
// Sequencer of the extended float divider: step counter and state machine.
// Depends on efd_pkg.
`timescale 1ns / 1ps
module efd_seq
  import efd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_go,
  input  logic skip,
  input  logic q_top,
  input  logic out_taken,
  output logic busy_n,
  output logic done,
  output ctl_t ctl
);
  state_t             state, state_next;
  logic [CntBits-1:0] cnt;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_go) state_next = skip ? ST_DONE : ST_DIV;
      ST_DIV:  if (cnt == CntBits'(MantBits - 1)) state_next = ST_NORM;
      ST_NORM: if (q_top) state_next = ST_DONE;
      ST_DONE: if (out_taken) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl.load  = (state == ST_IDLE) && in_go;
    ctl.step  = (state == ST_DIV);
    ctl.shift = (state == ST_NORM) && !q_top;
    busy_n    = (state == ST_IDLE);
    done      = (state == ST_DONE);
  end

  // hold state and count steps
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) cnt <= cnt + CntBits'(1);
      else                 cnt <= '0;
    end
  end
endmodule

// File: sv/extended_float_divider_top.sv
// Top level of the extended float divider: sequencer plus datapath.
// Depends on efd_pkg, efd_seq, efd_core.
`timescale 1ns / 1ps
//  channel | valid     | stall     | word
//  input   | in_valid  | in_stall  | dividend_*, divisor_*
//  output  | out_valid | out_stall | quot_*, underflow_flag, div_zero_flag
// An item takes one load, one divide step per quotient bit in the shared subtractor,
// one normalize shift per leading zero of the quotient plus a check that sees the top
// bit set, then the result state, which holds until out_stall is low.
// Zero dividend, underflow and divide-by-zero skip straight to the result.
// Reset is synchronous; in_stall is high while a word is in work or waiting.
module extended_float_divider_top
  import efd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      dividend_sign,
  input  logic signed [ExpBits-1:0] dividend_exp,
  input  logic [MantBits-1:0]       dividend_mant,
  input  logic                      divisor_sign,
  input  logic signed [ExpBits-1:0] divisor_exp,
  input  logic [MantBits-1:0]       divisor_mant,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      quot_sign,
  output logic signed [ExpBits-1:0] quot_exp,
  output logic [MantBits-1:0]       quot_mant,
  output logic                      underflow_flag,
  output logic                      div_zero_flag
);
  ctl_t ctl;
  logic skip, q_top, busy_n;

  assign in_stall = !busy_n;

  efd_seq u_seq (
    .clk(clk), .rst(rst), .in_go(in_valid), .skip(skip), .q_top(q_top),
    .out_taken(!out_stall), .busy_n(busy_n), .done(out_valid), .ctl(ctl)
  );

  efd_core u_core (
    .clk(clk), .ctl(ctl),
    .dividend_sign(dividend_sign), .dividend_exp(dividend_exp),
    .dividend_mant(dividend_mant), .divisor_sign(divisor_sign),
    .divisor_exp(divisor_exp), .divisor_mant(divisor_mant),
    .skip(skip), .q_top(q_top),
    .quot_sign(quot_sign), .quot_exp(quot_exp), .quot_mant(quot_mant),
    .underflow_flag(underflow_flag), .div_zero_flag(div_zero_flag)
  );
endmodule

// File: verif/tb_extended_float_divider_top.sv
// Testbench for the extended float divider: drives dividend/divisor words, predicts
// each quotient with a restoring-divide model and checks every result word.
// Depends on efd_pkg and extended_float_divider_top.
`timescale 1ns / 1ps
module tb_extended_float_divider_top;
  import efd_pkg::*;

  typedef struct packed {
    logic                      a_sign;
    logic signed [ExpBits-1:0] a_exp;
    logic [MantBits-1:0]       a_mant;
    logic                      b_sign;
    logic signed [ExpBits-1:0] b_exp;
    logic [MantBits-1:0]       b_mant;
  } operands_t;

  typedef struct packed {
    logic                      sign;
    logic signed [ExpBits-1:0] exp;
    logic [MantBits-1:0]       mant;
    logic                      unf;
    logic                      dz;
  } quotient_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic dividend_sign = 1'b0;
  logic signed [ExpBits-1:0] dividend_exp = '0;
  logic [MantBits-1:0] dividend_mant = '0;
  logic divisor_sign = 1'b0;
  logic signed [ExpBits-1:0] divisor_exp = '0;
  logic [MantBits-1:0] divisor_mant = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic quot_sign;
  logic signed [ExpBits-1:0] quot_exp;
  logic [MantBits-1:0] quot_mant;
  logic underflow_flag;
  logic div_zero_flag;

  operands_t pending_words[$];
  quotient_t expected_quots[$];
  int        error_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  always #6 clk = ~clk;

  extended_float_divider_top dut (.*);

  // Compute the expected quotient word for one operand pair
  function automatic quotient_t divide_model(operands_t op);
    quotient_t r;
    logic [MantBits-1:0] rem, dvs, q;
    int e;
    r = '0;
    if (op.a_mant == '0) begin
      r.sign = op.a_sign;
      return r;
    end
    rem = op.a_mant >> 1;
    dvs = op.b_mant >> 1;
    q = '0;
    e = int'(op.a_exp) - int'(op.b_exp) + 2;
    if (e < int'(ExpMin)) begin
      r.unf = 1'b1;
      e = int'(ExpMin);
    end
    if (dvs == '0) begin
      r.dz = 1'b1;
      e = int'(ExpMax);
    end
    if (!r.unf && !r.dz) begin
      for (int i = 0; i < MantBits; i++) begin
        q = q << 1;
        if (rem >= dvs) begin
          q[0] = 1'b1;
          rem = rem - dvs;
        end
        rem = rem << 1;
      end
      if (q != '0) begin
        while (!q[MantBits-1]) begin
          q = q << 1;
          e--;
        end
      end
    end
    if (e > 32767) e = 32767;
    if (e < -32768) e = -32768;
    r.sign = op.a_sign ^ op.b_sign;
    r.exp = e[ExpBits-1:0];
    r.mant = q;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Drive words from the pending queue; hold while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        operands_t op;
        op = pending_words.pop_front();
        expected_quots.push_back(divide_model(op));
        in_valid <= 1'b1;
        {dividend_sign, dividend_exp, dividend_mant} <= {op.a_sign, op.a_exp, op.a_mant};
        {divisor_sign, divisor_exp, divisor_mant} <= {op.b_sign, op.b_exp, op.b_mant};
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Check accepted result words; randomize stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_quots.size() == 0) begin
          report_mismatch("unexpected word", quot_mant, '0);
        end else begin
          quotient_t w;
          w = expected_quots.pop_front();
          if (quot_sign !== w.sign) report_mismatch("quot_sign", quot_sign, w.sign);
          if (quot_exp !== w.exp) report_mismatch("quot_exp", quot_exp, w.exp);
          if (quot_mant !== w.mant) report_mismatch("quot_mant", quot_mant, w.mant);
          if (underflow_flag !== w.unf) report_mismatch("underflow_flag", underflow_flag, w.unf);
          if (div_zero_flag !== w.dz) report_mismatch("div_zero_flag", div_zero_flag, w.dz);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [MantBits-1:0] rand_mant();
    logic [MantBits-1:0] m;
    m = {$urandom, $urandom};
    case ($urandom_range(9))
      0: m = m >> $urandom_range(63);
      1: m = MantBits'($urandom_range(3));
      2: m = '1;
      default: m[MantBits-1] = 1'b1;
    endcase
    return m;
  endfunction

  function automatic operands_t rand_operands();
    operands_t op;
    op.a_sign = 1'($urandom_range(1));
    op.b_sign = 1'($urandom_range(1));
    op.a_mant = rand_mant();
    op.b_mant = rand_mant();
    if ($urandom_range(3) == 0) begin
      op.a_exp = ExpBits'($urandom);
      op.b_exp = ExpBits'($urandom);
    end else begin
      op.a_exp = ExpBits'(int'($urandom_range(400)) - 200);
      op.b_exp = ExpBits'(int'($urandom_range(400)) - 200);
    end
    return op;
  endfunction

  task automatic push_word(logic as, logic [15:0] ae, logic [63:0] am,
                           logic bs, logic [15:0] be, logic [63:0] bm);
    pending_words.push_back({as, ae, am, bs, be, bm});
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || expected_quots.size() > 0) @(posedge clk);
  endtask

  // Directed cases, then random phases with varied idling and stalling
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    push_word(1'b0, 16'd0, 64'h8000_0000_0000_0000, 1'b0, 16'd0, 64'h8000_0000_0000_0000);
    push_word(1'b1, 16'd5, 64'h0, 1'b0, 16'd3, 64'hFFFF_FFFF_FFFF_FFFF);  // zero dividend
    push_word(1'b0, 16'd5, 64'h0, 1'b1, 16'd3, 64'h0);
    push_word(1'b1, 16'd10, 64'hC000_0000_0000_0000, 1'b0, 16'd1, 64'h0); // divide by zero
    push_word(1'b0, 16'd10, 64'hC000_0000_0000_0000, 1'b1, 16'd1, 64'h1); // divisor of one
    push_word(1'b0, 16'h8000, 64'h8000_0000_0000_0001, 1'b0, 16'h7FFF,
              64'hFFFF_FFFF_FFFF_FFFF);
    push_word(1'b1, 16'h8000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 16'h7FFF, 64'h0); // both flags
    push_word(1'b0, 16'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 16'h8000,
              64'h8000_0000_0000_0000);
    push_word(1'b0, 16'hC002, 64'h8000_0000_0000_0000, 1'b0, 16'd0, 64'h8000_0000_0000_0000);
    push_word(1'b0, 16'hC001, 64'h8000_0000_0000_0000, 1'b0, 16'd0, 64'h8000_0000_0000_0000);
    push_word(1'b1, 16'd0, 64'h1, 1'b0, 16'd0, 64'h8000_0000_0000_0000);  // zero quotient
    push_word(1'b0, 16'd0, 64'h3, 1'b1, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    push_word(1'b0, 16'd0, 64'h8000_0000_0000_0000, 1'b0, 16'd0, 64'h3);   // unnormalized
    push_word(1'b0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 16'h0001, 64'h2);
    push_word(1'b1, 16'd100, 64'h1234_5678_9ABC_DEF0, 1'b1, 16'd7, 64'h0FED_CBA9_8765_4321);
    drain();
    // run random phases, draining after each
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        3: begin send_idle_pct = 23; recv_stall_pct = 23; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 267; i++) pending_words.push_back(rand_operands());
      drain();
    end
    repeat (300) @(posedge clk);
    if (error_count == 0 && expected_quots.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(12 * 3000000);
    $display("== FAIL ==");
    $finish;
  end
endmodule
